FILE: rtl/core/ustc_pkg.sv
// ----------------------------------------------------------------------------
// ustc_pkg
// Shared types, constants and the month length table for the Unix seconds
// to calendar converter.
// ----------------------------------------------------------------------------
package ustc_pkg;

  localparam int SECONDS_WIDTH_DEF = 32;
  localparam int YEAR_W            = 12;

  localparam int EPOCH_YEAR = 1970;
  localparam int EPOCH_MOD4   = EPOCH_YEAR % 4;
  localparam int EPOCH_MOD100 = EPOCH_YEAR % 100;
  localparam int EPOCH_MOD400 = EPOCH_YEAR % 400;

  localparam logic [6:0] MOD100_LAST = 7'd99;
  localparam logic [8:0] MOD400_LAST = 9'd399;

  // seconds in a common and a leap year
  localparam logic [24:0] SECS_YEAR      = 25'd31536000;
  localparam logic [24:0] SECS_LEAP_YEAR = 25'd31622400;

  // step sizes of the time-of-day walk, tens first
  localparam logic [19:0] SECS_10_DAYS  = 20'd864000;
  localparam logic [19:0] SECS_PER_DAY  = 20'd86400;
  localparam logic [19:0] SECS_10_HOURS = 20'd36000;
  localparam logic [19:0] SECS_PER_HOUR = 20'd3600;
  localparam logic [19:0] SECS_10_MINS  = 20'd600;
  localparam logic [19:0] SECS_PER_MIN  = 20'd60;

  // zero-based month index
  localparam logic [3:0] MON_JAN = 4'd0;
  localparam logic [3:0] MON_FEB = 4'd1;
  localparam logic [3:0] MON_APR = 4'd3;
  localparam logic [3:0] MON_JUN = 4'd5;
  localparam logic [3:0] MON_SEP = 4'd8;
  localparam logic [3:0] MON_NOV = 4'd10;
  localparam logic [3:0] MON_DEC = 4'd11;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [8:0]  day_of_year;
    logic        is_leap_year;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } calendar_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      MON_FEB: len = leap ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // month length in seconds
  function automatic logic [21:0] month_secs(input logic [3:0] m, input logic leap);
    logic [21:0] secs;
    case (m)
      MON_FEB: secs = leap ? 22'd2505600 : 22'd2419200;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: secs = 22'd2592000;
      default: secs = 22'd2678400;
    endcase
    return secs;
  endfunction

endpackage

FILE: rtl/core/ustc_stream_if.sv
// ----------------------------------------------------------------------------
// ustc_stream_if
// Valid/ready stream channel carrying one word of payload_t per handshake.
// ----------------------------------------------------------------------------
interface ustc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/unix_seconds_to_calendar.sv
// The input is ready only in idle, so a new word is taken only after the last result
//   has been registered into the output word.
// All steps share one subtract/compare unit walking the seconds down: years, months,
//   then tens and units of days, hours and minutes; what is left is the second.
// Reset (rst, synchronous) returns the sequencer to idle and drops the output word.
// ----------------------------------------------------------------------------
// unix_seconds_to_calendar
// Converts seconds since 1970-01-01 UTC into calendar date and time of day.
// ----------------------------------------------------------------------------
module unix_seconds_to_calendar #(
  parameter int SECONDS_WIDTH = ustc_pkg::SECONDS_WIDTH_DEF
) (
  input logic           clk,
  input logic           rst,
  ustc_stream_if.sink   seconds,
  ustc_stream_if.source calendar
);
  import ustc_pkg::*;

  localparam int W  = SECONDS_WIDTH;
  localparam int YW = (W - 23 > YEAR_W) ? W - 23 : YEAR_W;  // years < 2^W / 31536000

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_YEAR  = 5'b00010,
    ST_MONTH = 5'b00100,
    ST_TIME  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  typedef enum logic [5:0] {
    PH_DAY10  = 6'b000001,
    PH_DAY1   = 6'b000010,
    PH_HOUR10 = 6'b000100,
    PH_HOUR1  = 6'b001000,
    PH_MIN10  = 6'b010000,
    PH_MIN1   = 6'b100000
  } phase_t;

  state_t        state;
  phase_t        phase;
  logic [W-1:0]  rem;
  logic [YW-1:0] year;
  logic [1:0]    mod4;
  logic [6:0]    mod100;
  logic [8:0]    mod400;
  logic [3:0]    mon;
  logic          leap;
  logic [4:0]    dom;
  logic [8:0]    doy;
  logic [4:0]    hour_r;
  logic [5:0]    min_r;
  calendar_t     out_word;
  logic          out_valid;

  logic          leap_now;
  logic [24:0]   ysecs;
  logic [19:0]   step;
  logic          coarse;
  logic [3:0]    inc;
  logic [W-1:0]  op_b;
  logic [W-1:0]  diff;
  logic          ge;

  assign leap_now = (mod400 == '0) || ((mod4 == '0) && (mod100 != '0));
  assign ysecs    = leap_now ? SECS_LEAP_YEAR : SECS_YEAR;
  assign coarse   = (phase == PH_DAY10) || (phase == PH_HOUR10) || (phase == PH_MIN10);
  assign inc      = coarse ? 4'd10 : 4'd1;

  always_comb begin
    case (phase)
      PH_DAY10:  step = SECS_10_DAYS;
      PH_DAY1:   step = SECS_PER_DAY;
      PH_HOUR10: step = SECS_10_HOURS;
      PH_HOUR1:  step = SECS_PER_HOUR;
      PH_MIN10:  step = SECS_10_MINS;
      default:   step = SECS_PER_MIN;
    endcase
  end

  always_comb begin
    case (state)
      ST_YEAR:  op_b = W'(ysecs);
      ST_MONTH: op_b = W'(month_secs(mon, leap));
      default:  op_b = W'(step);
    endcase
  end

  ustc_sub #(.WIDTH(W)) u_sub (
    .a    (rem),
    .b    (op_b),
    .diff (diff),
    .ge   (ge)
  );

  assign seconds.ready  = (state == ST_IDLE);
  assign calendar.valid = out_valid;
  assign calendar.data  = out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == ST_DONE) && (!out_valid || calendar.ready)) begin
        out_valid <= 1'b1;
      end else if (calendar.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (seconds.valid) begin
            rem    <= seconds.data;
            year   <= YW'(EPOCH_YEAR);
            mod4   <= 2'(EPOCH_MOD4);
            mod100 <= 7'(EPOCH_MOD100);
            mod400 <= 9'(EPOCH_MOD400);
            state  <= ST_YEAR;
          end
        end
        ST_YEAR: begin
          if (ge) begin
            rem    <= diff;
            year   <= year + 1'b1;
            mod4   <= mod4 + 1'b1;
            mod100 <= (mod100 == MOD100_LAST) ? '0 : mod100 + 1'b1;
            mod400 <= (mod400 == MOD400_LAST) ? '0 : mod400 + 1'b1;
          end else begin
            leap  <= leap_now;
            doy   <= '0;
            mon   <= MON_JAN;
            state <= ST_MONTH;
          end
        end
        ST_MONTH: begin
          if (ge && (mon != MON_DEC)) begin
            rem <= diff;
            mon <= mon + 1'b1;
            doy <= doy + 9'(month_len(mon, leap));
          end else begin
            dom    <= '0;
            hour_r <= '0;
            min_r  <= '0;
            phase  <= PH_DAY10;
            state  <= ST_TIME;
          end
        end
        ST_TIME: begin
          // each unit is counted in tens, then in ones
          if (ge) begin
            rem <= diff;
            case (phase)
              PH_DAY10, PH_DAY1: begin
                dom <= dom + 5'(inc);
                doy <= doy + 9'(inc);
              end
              PH_HOUR10, PH_HOUR1: hour_r <= hour_r + 5'(inc);
              default: min_r <= min_r + 6'(inc);
            endcase
          end else begin
            case (phase)
              PH_DAY10:  phase <= PH_DAY1;
              PH_DAY1:   phase <= PH_HOUR10;
              PH_HOUR10: phase <= PH_HOUR1;
              PH_HOUR1:  phase <= PH_MIN10;
              PH_MIN10:  phase <= PH_MIN1;
              default:   state <= ST_DONE;
            endcase
          end
        end
        ST_DONE: begin
          if (!out_valid || calendar.ready) begin
            out_word.year         <= year[11:0];
            out_word.month        <= mon + 1'b1;
            out_word.day_of_month <= dom + 1'b1;
            out_word.day_of_year  <= doy + 1'b1;
            out_word.is_leap_year <= leap;
            out_word.hour         <= hour_r;
            out_word.minute       <= min_r;
            out_word.second       <= rem[5:0];
            state                 <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_start: assert property (@(posedge clk) disable iff (rst)
    (seconds.valid && seconds.ready) |=> (state == ST_YEAR))
    else $error("conversion did not start after input word");

  a_year_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MONTH) |-> (rem < W'(SECS_LEAP_YEAR)))
    else $error("seconds left after the year walk exceed a year");

  a_sec: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> (rem < W'(SECS_PER_MIN)))
    else $error("seconds left after the minute walk exceed a minute");

  a_mods: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_YEAR) || (state == ST_MONTH)) |->
      ((mod4 == mod100[1:0]) && (mod4 == mod400[1:0])))
    else $error("leap year counters out of step");

  a_mon: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_TIME) || (state == ST_DONE)) |-> (mon <= MON_DEC))
    else $error("month index past December");

endmodule

FILE: rtl/core/ustc_sub.sv
// ----------------------------------------------------------------------------
// ustc_sub
// Shared subtract and compare unit: diff = a - b, ge when a >= b.
// ----------------------------------------------------------------------------
module ustc_sub #(
  parameter int WIDTH = 16
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  output logic [WIDTH-1:0] diff,
  output logic             ge
);
  logic [WIDTH:0] wide;

  assign wide = {1'b0, a} - {1'b0, b};
  assign diff = wide[WIDTH-1:0];
  assign ge   = ~wide[WIDTH];
endmodule

FILE: test/unix_seconds_to_calendar_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unix_seconds_to_calendar_test
// Streams Unix timestamps into the converter and checks every calendar word
// against a behavioral calendar walk, under random idling on both channels
// and one long stall of the calendar channel.
// ----------------------------------------------------------------------------
module unix_seconds_to_calendar_test;
  import ustc_pkg::*;

  localparam int SECONDS_WIDTH = SECONDS_WIDTH_DEF;
  localparam int RANDOM_ITEMS  = 1600;
  localparam int IDLE_PCT      = 29;
  localparam int STEADY_FROM   = 40000;
  localparam int STEADY_TO     = 100000;
  localparam int HOLD_AFTER    = 400;
  localparam int HOLD_CYCLES   = 1500;
  localparam int TAIL_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int PRINT_LIMIT   = 40;

  typedef struct {
    logic [31:0] stamp;
    calendar_t   cal;
  } conversion_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ustc_stream_if #(.payload_t(logic [SECONDS_WIDTH-1:0])) seconds_ch ();
  ustc_stream_if #(.payload_t(calendar_t))                calendar_ch ();

  unix_seconds_to_calendar #(.SECONDS_WIDTH(SECONDS_WIDTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .seconds  (seconds_ch),
    .calendar (calendar_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [31:0]  stamp_q[$];
  conversion_t  expected_q[$];
  int           total_stamps   = 0;
  int           stamps_taken   = 0;
  int           words_checked  = 0;
  int           leap_words     = 0;
  int           errors         = 0;
  int           cycle_count    = 0;
  int           min_year       = 4095;
  int           max_year       = 0;
  logic         hold_calendar  = 1'b0;
  wire          steady = (cycle_count >= STEADY_FROM) && (cycle_count < STEADY_TO);

  function automatic bit leap_of(int unsigned yr);
    return (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
  endfunction

  function automatic int unsigned year_days(int unsigned yr);
    return leap_of(yr) ? 366 : 365;
  endfunction

  // mon is 1-based
  function automatic int unsigned days_in_month(int unsigned mon, bit leap);
    int unsigned len;
    case (4'(mon - 1))
      MON_FEB:                            len = leap ? 29 : 28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 30;
      default:                            len = 31;
    endcase
    return len;
  endfunction

  function automatic calendar_t to_calendar(logic [31:0] stamp);
    calendar_t       c;
    longint unsigned s;
    longint unsigned days;
    int unsigned     yr;
    int unsigned     mon;
    bit              leap;
    s = 64'(stamp) & ((64'd1 << SECONDS_WIDTH) - 64'd1);
    c.second = 6'(s % 60);
    s = s / 60;
    c.minute = 6'(s % 60);
    s = s / 60;
    c.hour = 5'(s % 24);
    days = s / 24;
    yr = 1970;
    while (days >= year_days(yr)) begin
      days -= year_days(yr);
      yr++;
    end
    leap = leap_of(yr);
    c.year         = 12'(yr);
    c.is_leap_year = leap;
    c.day_of_year  = 9'(days + 1);
    mon = 1;
    while (mon < 12 && days >= days_in_month(mon, leap)) begin
      days -= days_in_month(mon, leap);
      mon++;
    end
    c.month        = 4'(mon);
    c.day_of_month = 5'(days + 1);
    return c;
  endfunction

  // days from the epoch to the first of the given month
  function automatic int unsigned epoch_days(int unsigned yr, int unsigned mon);
    int unsigned d;
    d = 0;
    for (int unsigned y = 1970; y < yr; y++) d += year_days(y);
    for (int unsigned m = 1; m < mon; m++) d += days_in_month(m, leap_of(yr));
    return d;
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic compare_field(string name, logic [31:0] stamp,
                               logic [11:0] got, logic [11:0] want);
    if (got !== want)
      report_mismatch($sformatf("stamp %0d %s got %0d want %0d", stamp, name, got, want));
  endtask

  // ---- sender: offers queued stamps, records expectations on handshake
  always @(posedge clk) begin
    if (rst) begin
      seconds_ch.valid <= 1'b0;
    end else begin
      if (seconds_ch.valid && seconds_ch.ready) begin
        expected_q.push_back('{stamp: seconds_ch.data, cal: to_calendar(seconds_ch.data)});
        stamps_taken++;
      end
      if (!seconds_ch.valid || seconds_ch.ready) begin
        if (stamp_q.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          seconds_ch.valid <= 1'b1;
          seconds_ch.data  <= stamp_q.pop_front();
        end else begin
          seconds_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---- receiver: random backpressure, checks each calendar word
  always @(posedge clk) begin
    conversion_t want;
    calendar_t   got;
    if (rst) begin
      calendar_ch.ready <= 1'b0;
    end else begin
      if (calendar_ch.valid && calendar_ch.ready) begin
        got = calendar_ch.data;
        if (expected_q.size() == 0) begin
          report_mismatch("calendar word with nothing outstanding");
        end else begin
          want = expected_q.pop_front();
          words_checked++;
          if (want.cal.is_leap_year) leap_words++;
          if (int'(want.cal.year) < min_year) min_year = int'(want.cal.year);
          if (int'(want.cal.year) > max_year) max_year = int'(want.cal.year);
          if (got !== want.cal) begin
            compare_field("year",         want.stamp, got.year,         want.cal.year);
            compare_field("month",        want.stamp, got.month,        want.cal.month);
            compare_field("day_of_month", want.stamp, got.day_of_month, want.cal.day_of_month);
            compare_field("day_of_year",  want.stamp, got.day_of_year,  want.cal.day_of_year);
            compare_field("is_leap_year", want.stamp, got.is_leap_year, want.cal.is_leap_year);
            compare_field("hour",         want.stamp, got.hour,         want.cal.hour);
            compare_field("minute",       want.stamp, got.minute,       want.cal.minute);
            compare_field("second",       want.stamp, got.second,       want.cal.second);
          end
        end
      end
      calendar_ch.ready <= !hold_calendar && (steady || $urandom_range(99) >= IDLE_PCT);
    end
  end

  // long stall on the calendar side so the converter backs up into its input
  initial begin
    wait (stamps_taken >= HOLD_AFTER);
    @(posedge clk);
    hold_calendar <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_calendar <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               expected_q.size());
      $display("unix_seconds_to_calendar_test: errors");
      $finish;
    end
  end

  initial begin
    logic [31:0] directed[];
    int unsigned offsets[];
    int unsigned yr;
    int unsigned mon;
    int unsigned kind;
    longint      span;

    directed = '{
      32'd0, 32'hFFFF_FFFF, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
      32'd31535999,    // last second of 1970
      32'd31536000,    // first second of 1971
      32'd68169600,    // leap day 1972
      32'd94694399,    // end of a leap year
      32'd951782400,   // leap day of a century divisible by 400
      32'd978307199,   // end of 2000
      32'd4102444799,  // end of 2099
      32'd4107456000,  // 2100 is not leap: Feb 28
      32'd4107542400,  // and then Mar 1
      32'd4291747200,  // first second of 2106
      32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555
    };
    offsets = '{0, 59, 60, 3599, 3600, 86399};

    seconds_ch.valid  = 1'b0;
    seconds_ch.data   = '0;
    calendar_ch.ready = 1'b0;

    foreach (directed[i]) stamp_q.push_back(directed[i]);
    repeat (RANDOM_ITEMS) begin
      kind = $urandom_range(3);
      if (kind == 0) begin
        stamp_q.push_back($urandom());
      end else if (kind == 3) begin
        span = longint'($urandom_range(49709)) * 86400
             + offsets[$urandom_range(offsets.size() - 1)];
        stamp_q.push_back(span[31:0]);
      end else begin
        // around a year start (kind 1) or a month start (kind 2)
        yr  = $urandom_range(2106, 1970);
        mon = (kind == 1) ? 1 : $urandom_range(12, 1);
        span = longint'(epoch_days(yr, mon)) * 86400
             + longint'($urandom_range(172799)) - 86400;
        stamp_q.push_back(span[31:0]);
      end
    end
    total_stamps = stamp_q.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    wait (stamps_taken == total_stamps && expected_q.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("converted %0d timestamps spanning years %0d to %0d, %0d in leap years",
             words_checked, min_year, max_year, leap_words);
    $display("random idling on both sides, a steady window and a %0d-cycle output stall",
             HOLD_CYCLES);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("unix_seconds_to_calendar_test: clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("unix_seconds_to_calendar_test: errors");
    end
    $finish;
  end

endmodule

FILE: unix_seconds_to_calendar.f
rtl/core/ustc_pkg.sv
rtl/core/ustc_stream_if.sv
rtl/core/ustc_sub.sv
rtl/core/unix_seconds_to_calendar.sv
test/unix_seconds_to_calendar_test.sv
